[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

[rtl/c6502_pkg.sv]
// Shared types and constants for the 6502 instruction core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package c6502_pkg;
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_EXEC  = 2'd2;
   localparam logic [1:0] CMD_KEY   = 2'd3;

   localparam logic [1:0] CSR_START  = 2'd0;
   localparam logic [1:0] CSR_PERIOD = 2'd1;
   localparam logic [1:0] CSR_VECTOR = 2'd2;

   localparam logic [15:0] KEY_COUNT_ADDR = 16'h00C6;
   localparam logic [15:0] KEY_BUF_ADDR   = 16'h0277;
   localparam logic [15:0] PERIOD_RESET   = 16'd10000;
   localparam logic [15:0] VECTOR_RESET   = 16'hFF48;

   typedef enum logic [3:0] {
      M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY,
      M_IND, M_IZX, M_IZY, M_REL
   } mode_type;

   typedef enum logic [5:0] {
      O_ADC, O_AND, O_ASL, O_BCC, O_BCS, O_BEQ, O_BIT, O_BMI, O_BNE, O_BPL, O_BRK,
      O_BVC, O_BVS, O_CLC, O_CLD, O_CLI, O_CLV, O_CMP, O_CPX, O_CPY, O_DEC, O_DEX,
      O_DEY, O_EOR, O_INC, O_INX, O_INY, O_JMP, O_JSR, O_LDA, O_LDX, O_LDY, O_LSR,
      O_NOP, O_ORA, O_PHA, O_PHP, O_PLA, O_PLP, O_ROL, O_ROR, O_RTI, O_RTS, O_SBC,
      O_SEC, O_SED, O_SEI, O_STA, O_STX, O_STY, O_TAX, O_TAY, O_TSX, O_TXA, O_TXS,
      O_TYA
   } op_type;

   typedef struct packed {
      logic     legal;
      op_type   op;
      mode_type mode;
   } decode_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CLEAR, S_KEY_RD, S_KEY_WAIT, S_KEY_WR, S_FETCH, S_FETCH_WAIT, S_B1, S_B2,
      S_PTR_LO, S_PTR_HI, S_OPER, S_EXEC, S_WRITE, S_PUSH, S_PULL, S_PULL_WAIT,
      S_IRQ, S_DONE
   } state_type;

   function automatic decode_type decode_op(input logic [7:0] oc);
      decode_type d;
      d.legal = 1'b1;
      d.op    = O_NOP;
      d.mode  = M_IMP;
      if (oc[1:0] == 2'd1) begin
         unique case (oc[7:5])
            3'd0: d.op = O_ORA;
            3'd1: d.op = O_AND;
            3'd2: d.op = O_EOR;
            3'd3: d.op = O_ADC;
            3'd4: d.op = O_STA;
            3'd5: d.op = O_LDA;
            3'd6: d.op = O_CMP;
            default: d.op = O_SBC;
         endcase
         unique case (oc[4:2])
            3'd0: d.mode = M_IZX;
            3'd1: d.mode = M_ZP;
            3'd2: d.mode = M_IMM;
            3'd3: d.mode = M_ABS;
            3'd4: d.mode = M_IZY;
            3'd5: d.mode = M_ZPX;
            3'd6: d.mode = M_ABY;
            default: d.mode = M_ABX;
         endcase
         if (oc == 8'h89) d.legal = 1'b0;
      end else if (oc[1:0] == 2'd2 && (!oc[7] || (oc[7:6] == 2'b11 && oc[2]))) begin
         unique case (oc[4:2])
            3'd1: d.mode = M_ZP;
            3'd2: d.mode = M_ACC;
            3'd3: d.mode = M_ABS;
            3'd5: d.mode = M_ZPX;
            3'd7: d.mode = M_ABX;
            default: d.legal = 1'b0;
         endcase
         unique case (oc[7:5])
            3'd0: d.op = O_ASL;
            3'd1: d.op = O_ROL;
            3'd2: d.op = O_LSR;
            3'd3: d.op = O_ROR;
            3'd6: d.op = O_DEC;
            default: d.op = O_INC;
         endcase
      end else begin
         unique case (oc)
            8'h00: d.op = O_BRK;
            8'h08: d.op = O_PHP;
            8'h10: begin d.op = O_BPL; d.mode = M_REL; end
            8'h18: d.op = O_CLC;
            8'h20: begin d.op = O_JSR; d.mode = M_ABS; end
            8'h24: begin d.op = O_BIT; d.mode = M_ZP; end
            8'h28: d.op = O_PLP;
            8'h2C: begin d.op = O_BIT; d.mode = M_ABS; end
            8'h30: begin d.op = O_BMI; d.mode = M_REL; end
            8'h38: d.op = O_SEC;
            8'h40: d.op = O_RTI;
            8'h48: d.op = O_PHA;
            8'h4C: begin d.op = O_JMP; d.mode = M_ABS; end
            8'h50: begin d.op = O_BVC; d.mode = M_REL; end
            8'h58: d.op = O_CLI;
            8'h60: d.op = O_RTS;
            8'h68: d.op = O_PLA;
            8'h6C: begin d.op = O_JMP; d.mode = M_IND; end
            8'h70: begin d.op = O_BVS; d.mode = M_REL; end
            8'h78: d.op = O_SEI;
            8'h84: begin d.op = O_STY; d.mode = M_ZP; end
            8'h86: begin d.op = O_STX; d.mode = M_ZP; end
            8'h88: d.op = O_DEY;
            8'h8A: d.op = O_TXA;
            8'h8C: begin d.op = O_STY; d.mode = M_ABS; end
            8'h8E: begin d.op = O_STX; d.mode = M_ABS; end
            8'h90: begin d.op = O_BCC; d.mode = M_REL; end
            8'h94: begin d.op = O_STY; d.mode = M_ZPX; end
            8'h96: begin d.op = O_STX; d.mode = M_ZPY; end
            8'h98: d.op = O_TYA;
            8'h9A: d.op = O_TXS;
            8'hA0: begin d.op = O_LDY; d.mode = M_IMM; end
            8'hA2: begin d.op = O_LDX; d.mode = M_IMM; end
            8'hA4: begin d.op = O_LDY; d.mode = M_ZP; end
            8'hA6: begin d.op = O_LDX; d.mode = M_ZP; end
            8'hA8: d.op = O_TAY;
            8'hAA: d.op = O_TAX;
            8'hAC: begin d.op = O_LDY; d.mode = M_ABS; end
            8'hAE: begin d.op = O_LDX; d.mode = M_ABS; end
            8'hB0: begin d.op = O_BCS; d.mode = M_REL; end
            8'hB4: begin d.op = O_LDY; d.mode = M_ZPX; end
            8'hB6: begin d.op = O_LDX; d.mode = M_ZPY; end
            8'hB8: d.op = O_CLV;
            8'hBA: d.op = O_TSX;
            8'hBC: begin d.op = O_LDY; d.mode = M_ABX; end
            8'hBE: begin d.op = O_LDX; d.mode = M_ABY; end
            8'hC0: begin d.op = O_CPY; d.mode = M_IMM; end
            8'hC4: begin d.op = O_CPY; d.mode = M_ZP; end
            8'hC8: d.op = O_INY;
            8'hCA: d.op = O_DEX;
            8'hCC: begin d.op = O_CPY; d.mode = M_ABS; end
            8'hD0: begin d.op = O_BNE; d.mode = M_REL; end
            8'hD8: d.op = O_CLD;
            8'hE0: begin d.op = O_CPX; d.mode = M_IMM; end
            8'hE4: begin d.op = O_CPX; d.mode = M_ZP; end
            8'hE8: d.op = O_INX;
            8'hEA: d.op = O_NOP;
            8'hEC: begin d.op = O_CPX; d.mode = M_ABS; end
            8'hF0: begin d.op = O_BEQ; d.mode = M_REL; end
            8'hF8: d.op = O_SED;
            default: d.legal = 1'b0;
         endcase
      end
      return d;
   endfunction
endpackage
`default_nettype wire

[rtl/c6502_ram.sv]
// Single-port byte memory of the core, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module c6502_ram #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] addr,
   input  wire logic [7:0]    wr_data,
   output logic      [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

[rtl/cpu_6502_instruction_core.sv]
// 6502 instruction core with private byte memory, one command per transfer.
// Write and start go straight to done; a key press reads the count, then writes
// key and count unless full; an execute (cut short if halted or illegal) takes
// one port pass per opcode, operand byte, pointer, operand, stack or IRQ push.
// One command at a time; result held in registers until its transfer.
// Reset: synchronous; a clearing pass writes zero to all MEMORY_BYTES addresses
// before the first command is taken.
`timescale 1ns / 1ps
`default_nettype none
module cpu_6502_instruction_core #(
   parameter int MEMORY_BYTES     = 65536,
   parameter int KEY_BUFFER_SLOTS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_mem_address,
   input  wire logic [7:0]  req_mem_data,
   input  wire logic [7:0]  req_key_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_program_counter,
   output logic [7:0]       rsp_accumulator,
   output logic [7:0]       rsp_index_x,
   output logic [7:0]       rsp_index_y,
   output logic [7:0]       rsp_stack_pointer,
   output logic [7:0]       rsp_status_byte,
   output logic             rsp_halted,
   output logic             rsp_illegal_opcode,
   output logic             rsp_key_buffer_full,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   import c6502_pkg::*;

   localparam int AW = $clog2(MEMORY_BYTES);

   state_type state_ff, state_in;
   logic [15:0] pc_ff, pc_in, start_ff, period_ff, vector_ff, cnt_ff, cnt_in;
   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, p_ff, p_in;
   logic        halt_ff, halt_in, ill_ff, ill_in, full_ff, full_in, rv_ff, rv_in;
   logic [7:0]  b1_ff, b1_in, val_ff, val_in, key_ff, key_in;
   logic [15:0] ea_ff, ea_in, tgt_ff, tgt_in;
   op_type      op_ff, op_in;
   mode_type    mode_ff, mode_in;
   logic [1:0]  nstk_ff, nstk_in;   // remaining stack bytes
   logic [23:0] stk_ff, stk_in;     // stack bytes, next at [7:0]
   logic [AW:0] clr_ff, clr_in;

   logic          m_we;
   logic [15:0]   m_addr;
   logic [7:0]    m_wd, m_rd;

   c6502_ram #(.DEPTH(MEMORY_BYTES), .AW(AW)) u_ram (
      .clock(clock), .wr_en(m_we), .addr(m_addr[AW-1:0]), .wr_data(m_wd), .rd_data(m_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= 16'd0;
         period_ff <= PERIOD_RESET;
         vector_ff <= VECTOR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START:  start_ff  <= csr_write_data;
            CSR_PERIOD: period_ff <= csr_write_data;
            CSR_VECTOR: vector_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         pc_ff <= 16'd0; a_ff <= 8'd0; x_ff <= 8'd0; y_ff <= 8'd0;
         sp_ff <= 8'hFF; p_ff <= 8'd0; cnt_ff <= 16'd0; halt_ff <= 1'b0;
         ill_ff <= 1'b0; full_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in;
         pc_ff <= pc_in; a_ff <= a_in; x_ff <= x_in; y_ff <= y_in;
         sp_ff <= sp_in; p_ff <= p_in; cnt_ff <= cnt_in; halt_ff <= halt_in;
         ill_ff <= ill_in; full_ff <= full_in; rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      b1_ff <= b1_in; val_ff <= val_in; key_ff <= key_in;
      ea_ff <= ea_in; tgt_ff <= tgt_in; op_ff <= op_in; mode_ff <= mode_in;
      nstk_ff <= nstk_in; stk_ff <= stk_in;
   end

   decode_type dec;
   logic [8:0] alu_sum;
   logic [7:0] alu_m, res;
   logic       take;
   assign dec = decode_op(m_rd);
   assign alu_m = (op_ff == O_SBC) ? ~val_ff : val_ff;
   assign alu_sum = {1'b0, a_ff} + {1'b0, alu_m} + {8'd0, p_ff[0]};

   always_comb begin
      logic [15:0] next, npc;
      logic [7:0]  cmpd;
      state_in = state_ff; clr_in = clr_ff;
      pc_in = pc_ff; a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff;
      p_in = p_ff; cnt_in = cnt_ff; halt_in = halt_ff; ill_in = ill_ff;
      full_in = full_ff; rv_in = rv_ff;
      b1_in = b1_ff; val_in = val_ff; key_in = key_ff;
      ea_in = ea_ff; tgt_in = tgt_ff; op_in = op_ff; mode_in = mode_ff;
      nstk_in = nstk_ff; stk_in = stk_ff;
      m_we = 1'b0; m_addr = 16'd0; m_wd = 8'd0;
      req_ready = 1'b0;
      res = 8'd0; take = 1'b0; cmpd = 8'd0;
      next = pc_ff;
      unique case (mode_ff)
         M_IMP, M_ACC: next = pc_ff + 16'd1;
         M_ABS, M_ABX, M_ABY, M_IND: next = pc_ff + 16'd3;
         default: next = pc_ff + 16'd2;
      endcase
      npc = next;
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1;
            m_addr = 16'(clr_ff[AW-1:0]);
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(MEMORY_BYTES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = !rv_ff;
            if (req_valid && !rv_ff) begin
               ill_in = 1'b0; full_in = 1'b0;
               unique case (req_command)
                  CMD_WRITE: begin
                     m_we = 1'b1; m_addr = req_mem_address; m_wd = req_mem_data;
                     state_in = S_DONE;
                  end
                  CMD_START: begin
                     pc_in = start_ff; cnt_in = 16'd0; halt_in = 1'b0;
                     state_in = S_DONE;
                  end
                  CMD_EXEC: begin
                     m_addr = pc_ff;
                     state_in = halt_ff ? S_DONE : S_FETCH_WAIT;
                  end
                  default: begin
                     key_in = req_key_code; m_addr = KEY_COUNT_ADDR;
                     state_in = S_KEY_WAIT;
                  end
               endcase
            end
         end
         S_KEY_WAIT: begin
            val_in = m_rd;
            if (m_rd >= 8'(KEY_BUFFER_SLOTS)) begin
               full_in = 1'b1; state_in = S_DONE;
            end else begin
               m_we = 1'b1; m_addr = KEY_BUF_ADDR + {8'd0, m_rd}; m_wd = key_ff;
               state_in = S_KEY_WR;
            end
         end
         S_KEY_WR: begin
            m_we = 1'b1; m_addr = KEY_COUNT_ADDR; m_wd = val_ff + 8'd1;
            state_in = S_DONE;
         end
         S_FETCH_WAIT: begin
            // opcode byte on read port
            op_in = dec.op; mode_in = dec.mode;
            if (!dec.legal) begin
               ill_in = 1'b1; state_in = S_DONE;
            end else begin
               m_addr = pc_ff + 16'd1;
               state_in = S_B1;
            end
         end
         S_B1: begin
            b1_in = m_rd;
            m_addr = pc_ff + 16'd2;
            state_in = S_B2;
         end
         S_B2: begin
            unique case (mode_ff)
               M_ZP:  ea_in = {8'd0, b1_ff};
               M_ZPX: ea_in = {8'd0, b1_ff + x_ff};
               M_ZPY: ea_in = {8'd0, b1_ff + y_ff};
               M_ABS: ea_in = {m_rd, b1_ff};
               M_ABX: ea_in = {m_rd, b1_ff} + {8'd0, x_ff};
               M_ABY: ea_in = {m_rd, b1_ff} + {8'd0, y_ff};
               M_IND: ea_in = {m_rd, b1_ff};
               M_IZX: ea_in = {8'd0, b1_ff + x_ff};
               M_IZY: ea_in = {8'd0, b1_ff};
               default: ea_in = 16'd0;
            endcase
            if (mode_ff == M_IND || mode_ff == M_IZX || mode_ff == M_IZY) begin
               m_addr = ea_in; state_in = S_PTR_LO;
            end else if (mode_ff == M_IMP || mode_ff == M_ACC || mode_ff == M_IMM ||
                         mode_ff == M_REL) begin
               val_in = (mode_ff == M_ACC) ? a_ff : b1_ff;
               state_in = S_EXEC;
            end else begin
               m_addr = ea_in; state_in = S_OPER;
            end
         end
         S_PTR_LO: begin
            tgt_in[7:0] = m_rd;
            m_addr = (mode_ff == M_IND) ? ea_ff + 16'd1 : {8'd0, ea_ff[7:0] + 8'd1};
            state_in = S_PTR_HI;
         end
         S_PTR_HI: begin
            ea_in = {m_rd, tgt_ff[7:0]};
            if (mode_ff == M_IZY) ea_in = {m_rd, tgt_ff[7:0]} + {8'd0, y_ff};
            m_addr = ea_in;
            state_in = S_OPER;
         end
         S_OPER: begin
            val_in = m_rd;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            nstk_in = 2'd0;
            state_in = S_IRQ;
            unique case (op_ff)
               O_ADC, O_SBC: begin
                  a_in = alu_sum[7:0];
                  p_in[0] = alu_sum[8];
                  p_in[6] = ~(a_ff[7] ^ alu_m[7]) & (a_ff[7] ^ alu_sum[7]);
                  p_in[1] = alu_sum[7:0] == 8'd0; p_in[7] = alu_sum[7];
               end
               O_AND, O_ORA, O_EOR, O_LDA, O_TXA, O_TYA: begin
                  unique case (op_ff)
                     O_AND: res = a_ff & val_ff;
                     O_ORA: res = a_ff | val_ff;
                     O_EOR: res = a_ff ^ val_ff;
                     O_TXA: res = x_ff;
                     O_TYA: res = y_ff;
                     default: res = val_ff;
                  endcase
                  a_in = res; p_in[1] = res == 8'd0; p_in[7] = res[7];
               end
               O_LDX, O_TAX, O_TSX, O_INX, O_DEX: begin
                  unique case (op_ff)
                     O_TAX: res = a_ff;
                     O_TSX: res = sp_ff;
                     O_INX: res = x_ff + 8'd1;
                     O_DEX: res = x_ff - 8'd1;
                     default: res = val_ff;
                  endcase
                  x_in = res; p_in[1] = res == 8'd0; p_in[7] = res[7];
               end
               O_LDY, O_TAY, O_INY, O_DEY: begin
                  unique case (op_ff)
                     O_TAY: res = a_ff;
                     O_INY: res = y_ff + 8'd1;
                     O_DEY: res = y_ff - 8'd1;
                     default: res = val_ff;
                  endcase
                  y_in = res; p_in[1] = res == 8'd0; p_in[7] = res[7];
               end
               O_STA, O_STX, O_STY: begin
                  m_we = 1'b1; m_addr = ea_ff;
                  m_wd = (op_ff == O_STA) ? a_ff : (op_ff == O_STX) ? x_ff : y_ff;
               end
               O_CMP, O_CPX, O_CPY: begin
                  res = (op_ff == O_CMP) ? a_ff : (op_ff == O_CPX) ? x_ff : y_ff;
                  cmpd = res - val_ff;
                  p_in[0] = res >= val_ff; p_in[1] = res == val_ff; p_in[7] = cmpd[7];
               end
               O_BIT: begin
                  p_in[1] = (val_ff & a_ff) == 8'd0;
                  p_in[7] = val_ff[7]; p_in[6] = val_ff[6];
               end
               O_ASL, O_ROL, O_LSR, O_ROR, O_INC, O_DEC: begin
                  unique case (op_ff)
                     O_ASL: begin res = {val_ff[6:0], 1'b0}; p_in[0] = val_ff[7]; end
                     O_ROL: begin res = {val_ff[6:0], p_ff[0]}; p_in[0] = val_ff[7]; end
                     O_LSR: begin res = {1'b0, val_ff[7:1]}; p_in[0] = val_ff[0]; end
                     O_ROR: begin res = {p_ff[0], val_ff[7:1]}; p_in[0] = val_ff[0]; end
                     O_INC: res = val_ff + 8'd1;
                     default: res = val_ff - 8'd1;
                  endcase
                  p_in[1] = res == 8'd0; p_in[7] = res[7];
                  if (mode_ff == M_ACC) a_in = res;
                  else begin m_we = 1'b1; m_addr = ea_ff; m_wd = res; end
               end
               O_TXS: sp_in = x_ff;
               O_BCC: take = !p_ff[0];
               O_BCS: take = p_ff[0];
               O_BNE: take = !p_ff[1];
               O_BEQ: take = p_ff[1];
               O_BPL: take = !p_ff[7];
               O_BMI: take = p_ff[7];
               O_BVC: take = !p_ff[6];
               O_BVS: take = p_ff[6];
               O_JMP: npc = ea_ff;
               O_JSR: begin
                  npc = ea_ff;
                  stk_in = {8'd0, 8'(({8'd0, pc_ff} + 24'd2) >> 0), 8'(pc_ff + 16'd2 >> 8)};
                  stk_in[15:8] = 8'(pc_ff + 16'd2);
                  nstk_in = 2'd2; state_in = S_PUSH;
               end
               O_PHA: begin stk_in = {16'd0, a_ff}; nstk_in = 2'd1; state_in = S_PUSH; end
               O_PHP: begin stk_in = {16'd0, p_ff}; nstk_in = 2'd1; state_in = S_PUSH; end
               O_PLA, O_PLP, O_RTS, O_RTI: ;
               O_CLC: p_in[0] = 1'b0;
               O_SEC: p_in[0] = 1'b1;
               O_CLD: p_in[3] = 1'b0;
               O_SED: p_in[3] = 1'b1;
               O_CLI: p_in[2] = 1'b0;
               O_SEI: p_in[2] = 1'b1;
               O_CLV: p_in[6] = 1'b0;
               O_BRK: begin halt_in = 1'b1; npc = pc_ff; end
               default: ;
            endcase
            if (op_ff == O_PLA || op_ff == O_PLP) nstk_in = 2'd1;
            if (op_ff == O_RTS) nstk_in = 2'd2;
            if (op_ff == O_RTI) nstk_in = 2'd3;
            if (op_ff == O_PLA || op_ff == O_PLP || op_ff == O_RTS || op_ff == O_RTI) begin
               sp_in = sp_ff + 8'd1; m_addr = {8'h01, sp_ff + 8'd1};
               state_in = S_PULL_WAIT;
            end
            if (take) npc = next + {{8{b1_ff[7]}}, b1_ff};
            pc_in = npc;
         end
         S_PUSH: begin
            m_we = 1'b1; m_addr = {8'h01, sp_ff}; m_wd = stk_ff[7:0];
            sp_in = sp_ff - 8'd1;
            stk_in = {8'd0, stk_ff[23:8]};
            nstk_in = nstk_ff - 2'd1;
            if (nstk_ff == 2'd1) state_in = S_IRQ;
         end
         S_PULL_WAIT: begin
            nstk_in = nstk_ff - 2'd1;
            unique case (op_ff)
               O_PLA: begin
                  a_in = m_rd; p_in[1] = m_rd == 8'd0; p_in[7] = m_rd[7];
               end
               O_PLP: p_in = m_rd & 8'hDF;
               O_RTS: begin
                  if (nstk_ff == 2'd2) tgt_in[7:0] = m_rd;
                  else pc_in = {m_rd, tgt_ff[7:0]} + 16'd1;
               end
               default: begin
                  if (nstk_ff == 2'd3) p_in = m_rd & 8'hDF;
                  else if (nstk_ff == 2'd2) tgt_in[15:8] = m_rd;
                  else pc_in = {tgt_ff[15:8], m_rd};
               end
            endcase
            if (nstk_ff == 2'd1) state_in = S_IRQ;
            else begin
               sp_in = sp_ff + 8'd1; m_addr = {8'h01, sp_ff + 8'd1};
            end
         end
         S_IRQ: begin
            cnt_in = cnt_ff + 16'd1;
            state_in = S_DONE;
            if (cnt_ff == period_ff) begin
               cnt_in = 16'd1;
               if (!p_ff[2]) begin
                  stk_in = {p_ff, pc_ff[15:8], pc_ff[7:0]};
                  nstk_in = 2'd3; pc_in = vector_ff;
                  op_in = O_NOP;
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            // interrupt pushes, then done
            m_we = 1'b1; m_addr = {8'h01, sp_ff}; m_wd = stk_ff[7:0];
            sp_in = sp_ff - 8'd1;
            stk_in = {8'd0, stk_ff[23:8]};
            nstk_in = nstk_ff - 2'd1;
            if (nstk_ff == 2'd1) state_in = S_DONE;
         end
         S_DONE: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_program_counter = pc_ff;
   assign rsp_accumulator = a_ff;
   assign rsp_index_x = x_ff;
   assign rsp_index_y = y_ff;
   assign rsp_stack_pointer = sp_ff;
   assign rsp_status_byte = p_ff & 8'hDF;
   assign rsp_halted = halt_ff;
   assign rsp_illegal_opcode = ill_ff;
   assign rsp_key_buffer_full = full_ff;
endmodule
`default_nettype wire

[rtl/c6502_checker.sv]
// Port-level checks for the 6502 instruction core, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module c6502_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_illegal_opcode,
   input wire logic rsp_key_buffer_full,
   input wire logic [7:0] rsp_status_byte
);
   // one command at a time: no new transfer while a result waits
   `ASSERT_IMPLIES(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_IMPLIES(a_flags_excl, clock, reset, rsp_valid,
      !(rsp_illegal_opcode && rsp_key_buffer_full))
   `ASSERT_IMPLIES(a_bit5, clock, reset, rsp_valid, !rsp_status_byte[5])
endmodule
bind cpu_6502_instruction_core c6502_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_illegal_opcode(rsp_illegal_opcode),
   .rsp_key_buffer_full(rsp_key_buffer_full), .rsp_status_byte(rsp_status_byte)
);
`default_nettype wire
